### design/mwc_pkg.sv
package mwc_pkg;

    // Widths fixed by the register map and the item formats.
    localparam int CFG_W   = 5;
    localparam int LABEL_W = 8;
    localparam int STAT_W  = 3;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 5'd5;
    localparam logic [CFG_W-1:0] SIZE_MIN       = 5'd5;

    // Item kinds.
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_TRY  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_BROKEN    = 3'd0,
        ST_NOT_WALL  = 3'd1,
        ST_SAME_ROOM = 3'd2,
        ST_INIT_DONE = 3'd3,
        ST_BAD_SIZE  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_RD_MID,
        S_RD_KEEP,
        S_RD_GONE,
        S_DECIDE,
        S_SWEEP,
        S_SWEEP_END,
        S_DONE
    } t_state;

endpackage

### design/mwc_if.sv
interface mwc_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [4:0] cand_row;
    logic [4:0] cand_col;

    modport source (output valid, kind, cand_row, cand_col, input ready);
    modport sink   (input valid, kind, cand_row, cand_col, output ready);
endinterface

interface mwc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] walls_left;
    logic       finished;

    modport source (output valid, status, walls_left, finished, input ready);
    modport sink   (input valid, status, walls_left, finished, output ready);
endinterface

### design/mwc_grid_store.sv
module mwc_grid_store
    import mwc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [LABEL_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [LABEL_W-1:0] o_rdata
);

    logic [LABEL_W-1:0] r_mem [DEPTH];
    logic [LABEL_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/maze_wall_carver_room_merge.sv
// The grid memory holds CELLS = (MAX_ROWS+1)*(MAX_COLUMNS+1) cells (1024 by default). An init item
// and a successful wall break each sweep every cell; a rejected item returns its result without
// a sweep. The core takes one item at a time, since the full sweep of the grid memory runs
// through its single write port, one cell per cycle.
// Reset (synchronous, active low) clears the control state, sets both size registers to 5 and
// walls-left to 0. The grid memory is not cleared; it is defined only after the first init item.
module maze_wall_carver_room_merge
    import mwc_pkg::*;
#(
    parameter int MAX_ROWS    = 31,
    parameter int MAX_COLUMNS = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mwc_item_if.sink         i_item,
    mwc_result_if.source     o_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Grid geometry. The memory is laid out row-major with a stride of MAX_COLUMNS+1.
    localparam int STRIDE = MAX_COLUMNS + 1;
    localparam int CELLS  = (MAX_ROWS + 1) * STRIDE;
    localparam int AW     = $clog2(CELLS);
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int CW     = $clog2(MAX_COLUMNS + 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS);
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS);

    function automatic logic [AW-1:0] cell_addr(input logic [5:0] row, input logic [5:0] col);
        cell_addr = AW'(int'(row) * STRIDE + int'(col));
    endfunction

    // Control and configuration registers.
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_row_cnt;
    logic [CFG_W-1:0]   r_col_cnt;
    logic [LABEL_W-1:0] r_walls;
    t_status            r_status;
    logic               r_out_valid;

    // Item and sweep registers.
    logic [4:0]         r_wr;
    logic [4:0]         r_wc;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [LABEL_W-1:0] r_label;
    logic [LABEL_W-1:0] r_mid;
    logic [LABEL_W-1:0] r_keep;
    logic [LABEL_W-1:0] r_gone;
    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;

    // Output payload registers.
    logic [STAT_W-1:0]  r_out_status;
    logic [LABEL_W-1:0] r_out_walls;
    logic               r_out_fin;

    // Memory port signals.
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [LABEL_W-1:0] w_mem_wdata;
    logic [AW-1:0]      w_mem_raddr;
    logic [LABEL_W-1:0] w_mem_rdata;

    logic               w_item_ready;
    logic               w_accept;
    logic               w_out_load;
    logic               w_size_ok;
    logic               w_geom_bad;
    logic [LABEL_W-1:0] w_init_walls;
    logic               w_last;
    logic               w_room_cell;
    logic               w_break;
    logic               w_relabel;
    logic [AW-1:0]      w_sweep_addr;
    logic [AW-1:0]      w_mid_addr;
    logic [AW-1:0]      w_keep_addr;
    logic [AW-1:0]      w_gone_addr;

    mwc_grid_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign w_accept = i_item.valid && w_item_ready;
    assign i_item.ready = w_item_ready;

    // The sizes must be odd and lie between 5 and the grid maximum.
    assign w_size_ok = (r_row_cnt >= SIZE_MIN) && (r_col_cnt >= SIZE_MIN)
                    && (7'(r_row_cnt) <= 7'(MAX_ROWS)) && (7'(r_col_cnt) <= 7'(MAX_COLUMNS))
                    && r_row_cnt[0] && r_col_cnt[0];

    // A candidate wall must be interior with row plus column odd. These checks need no memory.
    assign w_geom_bad = (i_item.cand_row == 5'd0) || (i_item.cand_col == 5'd0)
                     || (6'(i_item.cand_row) + 6'd1 >= 6'(r_row_cnt))
                     || (6'(i_item.cand_col) + 6'd1 >= 6'(r_col_cnt))
                     || (i_item.cand_row[0] == i_item.cand_col[0]);

    // Rooms are (rows/2) x (columns/2); a spanning tree needs one wall fewer than that.
    assign w_init_walls = 8'(r_row_cnt[4:1]) * 8'(r_col_cnt[4:1]) - 8'd1;

    assign w_last       = (r_row == ROW_LAST) && (r_col == COL_LAST);
    assign w_sweep_addr = cell_addr(6'(r_row), 6'(r_col));
    assign w_room_cell  = r_row[0] && r_col[0]
                       && (8'(r_row) < 8'(r_row_cnt)) && (8'(r_col) < 8'(r_col_cnt));

    // On an even row the wall joins the room below (kept) and the room above (replaced).
    // On an odd row it joins the room on the left (kept) and the room on the right (replaced).
    assign w_mid_addr = cell_addr(6'(r_wr), 6'(r_wc));
    always_comb begin
        if (!r_wr[0]) begin
            w_keep_addr = cell_addr(6'(r_wr) + 6'd1, 6'(r_wc));
            w_gone_addr = cell_addr(6'(r_wr) - 6'd1, 6'(r_wc));
        end else begin
            w_keep_addr = cell_addr(6'(r_wr), 6'(r_wc) - 6'd1);
            w_gone_addr = cell_addr(6'(r_wr), 6'(r_wc) + 6'd1);
        end
    end

    // In the decide state the read data holds the replaced side's label.
    assign w_break = (r_mid == '0) && (r_keep != '0) && (w_mem_rdata != '0)
                  && (r_keep != w_mem_rdata);

    // During the relabel sweep the read data belongs to the cell read in the cycle before.
    assign w_relabel = r_pend && (w_mem_rdata == r_gone);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_size_ok) begin
                        n_state = S_DONE;
                    end else if (i_item.kind == KIND_INIT) begin
                        n_state = S_INIT;
                    end else if (w_geom_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RD_MID;
                    end
                end
            end
            S_INIT: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_RD_MID:  n_state = S_RD_KEEP;
            S_RD_KEEP: n_state = S_RD_GONE;
            S_RD_GONE: n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = w_break ? S_SWEEP : S_DONE;
            end
            S_SWEEP: begin
                if (w_last) begin
                    n_state = S_SWEEP_END;
                end
            end
            S_SWEEP_END: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: memory port control, input ready and result loading.
    always_comb begin
        w_item_ready = 1'b0;
        w_mem_we     = 1'b0;
        w_mem_waddr  = w_sweep_addr;
        w_mem_wdata  = '0;
        w_mem_raddr  = w_sweep_addr;
        w_out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: w_item_ready = 1'b1;
            S_INIT: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = w_room_cell ? r_label : '0;
            end
            S_RD_MID:  w_mem_raddr = w_mid_addr;
            S_RD_KEEP: w_mem_raddr = w_keep_addr;
            S_RD_GONE: w_mem_raddr = w_gone_addr;
            S_DECIDE: begin
                // The broken wall takes the kept label before the sweep starts.
                w_mem_we    = w_break;
                w_mem_waddr = w_mid_addr;
                w_mem_wdata = r_keep;
            end
            S_SWEEP, S_SWEEP_END: begin
                w_mem_we    = w_relabel;
                w_mem_waddr = r_pend_addr;
                w_mem_wdata = r_keep;
            end
            S_DONE: w_out_load = !r_out_valid || o_result.ready;
            default: begin
                w_item_ready = 1'b0;
            end
        endcase
    end

    // Control registers and the datapath of the sweeps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_cnt   <= CFG_SIZE_RESET;
            r_col_cnt   <= CFG_SIZE_RESET;
            r_walls     <= '0;
            r_status    <= ST_BROKEN;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_COUNT:    r_row_cnt <= i_cfg_data;
                    CFG_COLUMN_COUNT: r_col_cnt <= i_cfg_data;
                    default:          r_row_cnt <= r_row_cnt;
                endcase
            end

            // The pending flag is already clear here; the end of every sweep drops it.
            if (w_accept) begin
                r_wr    <= i_item.cand_row;
                r_wc    <= i_item.cand_col;
                r_row   <= '0;
                r_col   <= '0;
                r_label <= 8'd1;
                if (!w_size_ok) begin
                    r_status <= ST_BAD_SIZE;
                end else if (i_item.kind == KIND_INIT) begin
                    r_status <= ST_INIT_DONE;
                    r_walls  <= w_init_walls;
                end else if (w_geom_bad) begin
                    r_status <= ST_NOT_WALL;
                end
            end

            case (r_state)
                S_INIT, S_SWEEP: begin
                    if (r_col == COL_LAST) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    if (r_state == S_INIT && w_room_cell) begin
                        r_label <= r_label + 8'd1;
                    end
                    if (r_state == S_SWEEP) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= w_sweep_addr;
                    end
                end
                S_RD_KEEP: r_mid  <= w_mem_rdata;
                S_RD_GONE: r_keep <= w_mem_rdata;
                S_DECIDE: begin
                    r_gone <= w_mem_rdata;
                    if ((r_mid != '0) || (r_keep == '0) || (w_mem_rdata == '0)) begin
                        r_status <= ST_NOT_WALL;
                    end else if (r_keep == w_mem_rdata) begin
                        r_status <= ST_SAME_ROOM;
                    end else begin
                        r_status <= ST_BROKEN;
                        if (r_walls != '0) begin
                            r_walls <= r_walls - 8'd1;
                        end
                    end
                end
                S_SWEEP_END: r_pend <= 1'b0;
                default: r_pend <= r_pend;
            endcase

            // The output register frees the core while a result waits for its transfer.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_walls  <= r_walls;
            r_out_fin    <= (r_walls == '0);
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out_status;
    assign o_result.walls_left = r_out_walls;
    assign o_result.finished   = r_out_fin;

    // Walls-left only moves on an init transfer or by a single step down.
    a_walls_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && i_item.kind == KIND_INIT)
        |=> (r_walls == $past(r_walls)) || (r_walls == $past(r_walls) - 8'd1))
        else $error("walls-left changed by more than one step");

    // The relabel sweep only ever writes the kept label.
    a_sweep_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) || (r_state == S_SWEEP_END)) && w_mem_we
        |-> (w_mem_wdata == r_keep) && (r_keep != r_gone))
        else $error("relabel sweep wrote an unexpected label");

    // A new result appears only after the core reached its done state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

endmodule
